// ===== sv/ssr_pkg.sv =====
package ssr_pkg;

  // widths fixed by the word formats
  localparam int unsigned SeqBitsW  = 64;
  localparam int unsigned CfgW      = 7;
  localparam int unsigned IdxOutW   = 6;
  localparam int unsigned WeightW   = 17;
  localparam int unsigned StepW     = 3;

  // configuration register indexes
  localparam logic REG_SEQ_LENGTH     = 1'b0;
  localparam logic REG_DISTANCE_LIMIT = 1'b1;

  localparam logic [CfgW-1:0] SEQ_LENGTH_RST     = 7'd64;
  localparam logic [CfgW-1:0] DISTANCE_LIMIT_RST = 7'd0;

  typedef logic [StepW-1:0] step_t;

  // microprogram addresses
  localparam step_t STEP_LOAD   = 3'd0;
  localparam step_t STEP_READ_A = 3'd1;
  localparam step_t STEP_HOLD_A = 3'd2;
  localparam step_t STEP_SCAN   = 3'd3;
  localparam step_t STEP_DRAIN1 = 3'd4;
  localparam step_t STEP_DRAIN2 = 3'd5;
  localparam step_t STEP_EMIT   = 3'd6;
  localparam step_t STEP_NEXT   = 3'd7;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_NOT_START,
    JC_B_NOT_LAST,
    JC_OUT_BUSY,
    JC_A_NOT_LAST
  } jump_e;

  // datapath control word
  typedef struct packed {
    logic load_en;
    logic rd_a;
    logic clr_cnt;
    logic ld_a;
    logic issue;
    logic emit;
    logic adv_a;
  } ctrl_t;

  typedef struct packed {
    ctrl_t ctrl;
    jump_e jc;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic b_last;
    logic a_last;
    logic out_busy;
  } status_t;

  // floor(65536 / (1 + count)) for count 0..63
  localparam logic [WeightW-1:0] WEIGHT_LUT [64] = '{
    17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922, 17'd9362,  17'd8192,
    17'd7281,  17'd6553,  17'd5957,  17'd5461,  17'd5041,  17'd4681,  17'd4369,  17'd4096,
    17'd3855,  17'd3640,  17'd3449,  17'd3276,  17'd3120,  17'd2978,  17'd2849,  17'd2730,
    17'd2621,  17'd2520,  17'd2427,  17'd2340,  17'd2259,  17'd2184,  17'd2114,  17'd2048,
    17'd1985,  17'd1927,  17'd1872,  17'd1820,  17'd1771,  17'd1724,  17'd1680,  17'd1638,
    17'd1598,  17'd1560,  17'd1524,  17'd1489,  17'd1456,  17'd1424,  17'd1394,  17'd1365,
    17'd1337,  17'd1310,  17'd1285,  17'd1260,  17'd1236,  17'd1213,  17'd1191,  17'd1170,
    17'd1149,  17'd1129,  17'd1110,  17'd1092,  17'd1074,  17'd1057,  17'd1040,  17'd1024
  };

endpackage

// ===== sv/ssr_store.sv =====
module ssr_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ssr_sequencer.sv =====
module ssr_sequencer
  import ssr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  step_t  pc_q, pc_d;
  ucode_t uw;
  logic   taken;

  // microprogram rom
  function automatic ucode_t ucode(input step_t pc);
    ucode_t w;
    w = '{ctrl: '0, jc: JC_NEVER, target: STEP_LOAD};
    case (pc)
      STEP_LOAD: begin
        w.ctrl.load_en = 1'b1;
        w.jc           = JC_NOT_START;
        w.target       = STEP_LOAD;
      end
      STEP_READ_A: begin
        w.ctrl.rd_a    = 1'b1;
        w.ctrl.clr_cnt = 1'b1;
      end
      STEP_HOLD_A: begin
        w.ctrl.ld_a = 1'b1;
      end
      STEP_SCAN: begin
        w.ctrl.issue = 1'b1;
        w.jc         = JC_B_NOT_LAST;
        w.target     = STEP_SCAN;
      end
      STEP_DRAIN1: begin
        w.jc = JC_NEVER;
      end
      STEP_DRAIN2: begin
        w.jc = JC_NEVER;
      end
      STEP_EMIT: begin
        w.ctrl.emit = 1'b1;
        w.jc        = JC_OUT_BUSY;
        w.target    = STEP_EMIT;
      end
      STEP_NEXT: begin
        // fall-through wraps to the load step
        w.ctrl.adv_a = 1'b1;
        w.jc         = JC_A_NOT_LAST;
        w.target     = STEP_READ_A;
      end
      default: begin
        w.jc = JC_NEVER;
      end
    endcase
    return w;
  endfunction

  assign uw     = ucode(pc_q);
  assign ctrl_o = uw.ctrl;

  always_comb begin
    case (uw.jc)
      JC_NEVER:      taken = 1'b0;
      JC_NOT_START:  taken = !status_i.start;
      JC_B_NOT_LAST: taken = !status_i.b_last;
      JC_OUT_BUSY:   taken = status_i.out_busy;
      JC_A_NOT_LAST: taken = !status_i.a_last;
      default:       taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = taken ? uw.target : pc_q + step_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

`ifndef SYNTHESIS
  a_start_goes_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == STEP_LOAD && status_i.start) |=> pc_q == STEP_READ_A)
    else $error("closing word did not start the scan");
`endif

endmodule

// ===== sv/ssr_datapath.sv =====
module ssr_datapath
  import ssr_pkg::*;
#(
  parameter int unsigned MAX_SEQUENCES = 64,
  parameter int unsigned MAX_LENGTH    = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CfgW-1:0]       cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic [SeqBitsW-1:0]   sequence_bits_i,
  input  logic                  last_sequence_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [IdxOutW-1:0]    sequence_index_o,
  output logic [IdxOutW-1:0]    neighbour_count_o,
  output logic [WeightW-1:0]    weight_q16_o,
  output logic                  overflow_flag_o,
  output logic                  last_result_o,
  input  ctrl_t                 ctrl_i,
  output status_t               status_o
);

  localparam int unsigned IW = $clog2(MAX_SEQUENCES);
  localparam int unsigned CW = $clog2(MAX_SEQUENCES + 1);
  localparam int unsigned DW = $clog2(MAX_LENGTH + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_SEQUENCES);

  logic [CfgW-1:0] seq_length_q, distance_limit_q;
  logic [CW-1:0]   loaded_q;
  logic            dropped_q;
  logic [IW-1:0]   a_q, b_q, cnt_q, last_idx;
  logic [MAX_LENGTH-1:0] a_word_q, rd_word, diff, len_mask;
  logic [DW-1:0]   dist_q;
  logic            tag1_q, tag2_q;
  logic            full, store_we, hit, out_busy, out_load;

  logic            out_valid_q;
  logic [IdxOutW-1:0] idx_out_q, cnt_out_q;
  logic [WeightW-1:0] weight_q;
  logic            ovf_q, last_q;

  assign full     = (loaded_q == FULL);
  assign last_idx = IW'(loaded_q - CW'(1));
  assign store_we = ctrl_i.load_en && in_valid_i && !full;

  ssr_store #(
    .DEPTH (MAX_SEQUENCES),
    .WIDTH (MAX_LENGTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (IW'(loaded_q)),
    .wdata_i (sequence_bits_i[MAX_LENGTH-1:0]),
    .raddr_i (ctrl_i.rd_a ? a_q : b_q),
    .rdata_o (rd_word)
  );

  // positions at or above the length take no part
  always_comb begin
    for (int i = 0; i < MAX_LENGTH; i++) begin
      len_mask[i] = (CfgW'(i) < seq_length_q);
    end
  end

  assign diff     = (a_word_q ^ rd_word) & len_mask;
  assign hit      = (CfgW'(dist_q) < distance_limit_q);
  assign out_busy = out_valid_q && out_stall_i;
  assign out_load = ctrl_i.emit && !out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_length_q     <= SEQ_LENGTH_RST;
      distance_limit_q <= DISTANCE_LIMIT_RST;
      loaded_q         <= '0;
      dropped_q        <= 1'b0;
      a_q              <= '0;
      b_q              <= '0;
      cnt_q            <= '0;
      tag1_q           <= 1'b0;
      tag2_q           <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SEQ_LENGTH:     seq_length_q     <= cfg_wdata_i;
          REG_DISTANCE_LIMIT: distance_limit_q <= cfg_wdata_i;
          default:            seq_length_q     <= seq_length_q;
        endcase
      end

      if (ctrl_i.load_en && in_valid_i) begin
        if (full) begin
          dropped_q <= 1'b1;
        end else begin
          loaded_q <= loaded_q + CW'(1);
        end
      end

      if (ctrl_i.adv_a) begin
        if (status_o.a_last) begin
          a_q       <= '0;
          loaded_q  <= '0;
          dropped_q <= 1'b0;
        end else begin
          a_q <= a_q + IW'(1);
        end
      end

      if (ctrl_i.clr_cnt) begin
        b_q <= '0;
      end else if (ctrl_i.issue) begin
        b_q <= b_q + IW'(1);
      end

      if (ctrl_i.clr_cnt) begin
        cnt_q <= '0;
      end else if (tag2_q && hit) begin
        cnt_q <= cnt_q + IW'(1);
      end

      tag1_q <= ctrl_i.issue && (b_q != a_q);
      tag2_q <= tag1_q;

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_a) begin
      a_word_q <= rd_word;
    end
    dist_q <= DW'($countones(diff));
    if (out_load) begin
      idx_out_q <= IdxOutW'(a_q);
      cnt_out_q <= IdxOutW'(cnt_q);
      weight_q  <= WEIGHT_LUT[IdxOutW'(cnt_q)];
      ovf_q     <= dropped_q;
      last_q    <= status_o.a_last;
    end
  end

  assign status_o.start    = in_valid_i && last_sequence_i;
  assign status_o.b_last   = (b_q == last_idx);
  assign status_o.a_last   = (a_q == last_idx);
  assign status_o.out_busy = out_busy;

  assign out_valid_o       = out_valid_q;
  assign sequence_index_o  = idx_out_q;
  assign neighbour_count_o = cnt_out_q;
  assign weight_q16_o      = weight_q;
  assign overflow_flag_o   = ovf_q;
  assign last_result_o     = last_q;

`ifndef SYNTHESIS
  a_emit_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit |-> (!tag1_q && !tag2_q))
    else $error("result taken before the compare pipeline drained");

  a_loaded_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= FULL)
    else $error("fill count beyond store depth");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dropped_q |-> full)
    else $error("drop mark set with room in the store");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.issue |-> (b_q <= last_idx))
    else $error("scan read beyond the loaded set");
`endif

endmodule

// ===== sv/sequence_similarity_reweighting.sv =====
// channel  direction  handshake                 word
// cfg      in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
// in       in         in_valid_i / in_stall_o   sequence_bits_i, last_sequence_i
// out      out        out_valid_o / out_stall_i index, count, weight, overflow, last
//
// loading takes one word a cycle; the word marked last closes the set of n words
// each stored word then runs through its steps in order: operand fetch, one compare a cycle
// through the single store read port, two drain steps, the result and the advance
// loading resumes once every stored word of the set has had its result and advance
// reset clears control and restores the register defaults; the store needs no clearing
// a stalled output holds the sequencer on its result step; input stalls outside loading
module sequence_similarity_reweighting
  import ssr_pkg::*;
#(
  parameter int unsigned MAX_SEQUENCES = 64,
  parameter int unsigned MAX_LENGTH    = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  // input words
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SeqBitsW-1:0] sequence_bits_i,
  input  logic                last_sequence_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [IdxOutW-1:0]  sequence_index_o,
  output logic [IdxOutW-1:0]  neighbour_count_o,
  output logic [WeightW-1:0]  weight_q16_o,
  output logic                overflow_flag_o,
  output logic                last_result_o
);

  ctrl_t   ctrl;
  status_t status;

  // step counter and microprogram
  ssr_sequencer u_sequencer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // store, distance pipeline, counters and output register
  ssr_datapath #(
    .MAX_SEQUENCES (MAX_SEQUENCES),
    .MAX_LENGTH    (MAX_LENGTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .sequence_bits_i   (sequence_bits_i),
    .last_sequence_i   (last_sequence_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .sequence_index_o  (sequence_index_o),
    .neighbour_count_o (neighbour_count_o),
    .weight_q16_o      (weight_q16_o),
    .overflow_flag_o   (overflow_flag_o),
    .last_result_o     (last_result_o),
    .ctrl_i            (ctrl),
    .status_o          (status)
  );

  // words are taken only on the load step
  assign in_stall_o = !ctrl.load_en;

endmodule

// ===== dv/sequence_similarity_reweighting_tb.sv =====
module sequence_similarity_reweighting_tb;
  import ssr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SetCapacity  = 64;
  localparam int unsigned MaxLen       = 64;
  // cycles left to the sequencer after the final result of a set
  localparam int unsigned SettleCycles = 24;

  // one expected result word
  typedef struct packed {
    logic [IdxOutW-1:0] seq_idx;
    logic [IdxOutW-1:0] nbr_count;
    logic [WeightW-1:0] weight;
    logic               overflow;
    logic               closing;
  } reweight_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [SeqBitsW-1:0] sequence_bits_i;
  logic                last_sequence_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [IdxOutW-1:0]  sequence_index_o;
  logic [IdxOutW-1:0]  neighbour_count_o;
  logic [WeightW-1:0]  weight_q16_o;
  logic                overflow_flag_o;
  logic                last_result_o;

  // predictor state: its own copy of the store and the registers
  logic [SeqBitsW-1:0] held_seqs [SetCapacity];
  int unsigned         held_words;
  logic                set_dropped;
  logic [CfgW-1:0]     len_cfg;
  logic [CfgW-1:0]     limit_cfg;
  reweight_t           expected_weights [$];
  reweight_t           want;

  int unsigned mismatches   = 0;
  int unsigned words_sent   = 0;
  int unsigned hold_off_len = 0;
  int unsigned gap_odds     = 4;
  bit          idle_enable  = 1'b1;

  sequence_similarity_reweighting DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .sequence_bits_i,
    .last_sequence_i,
    .out_valid_o,
    .out_stall_i,
    .sequence_index_o,
    .neighbour_count_o,
    .weight_q16_o,
    .overflow_flag_o,
    .last_result_o
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // store one accepted word; the word marked last computes the whole set
  function automatic void absorb_word(input logic [SeqBitsW-1:0] bits, input logic closing);
    logic [SeqBitsW-1:0] mask;
    int unsigned         span;
    int unsigned         cnt;
    reweight_t           r;
    if (held_words < SetCapacity) begin
      held_seqs[held_words] = bits;
      held_words++;
    end else begin
      // store full: word dropped, set still closes below if marked last
      set_dropped = 1'b1;
    end
    if (!closing) return;
    // lengths past the maximum clamp; length zero masks every position
    span = (len_cfg > MaxLen) ? MaxLen : len_cfg;
    mask = (span >= 64) ? '1 : ((64'd1 << span) - 64'd1);
    for (int unsigned a = 0; a < held_words; a++) begin
      cnt = 0;
      // a limit of zero switches neighbour counting off
      if (limit_cfg != 0) begin
        for (int unsigned b = 0; b < held_words; b++) begin
          if (b != a && $countones((held_seqs[a] ^ held_seqs[b]) & mask) < limit_cfg) cnt++;
        end
      end
      r.seq_idx   = IdxOutW'(a);
      r.nbr_count = IdxOutW'(cnt);
      r.weight    = WeightW'(32'd65536 / (32'd1 + cnt));
      r.overflow  = set_dropped;
      r.closing   = (a + 1 == held_words);
      expected_weights.push_back(r);
    end
    held_words  = 0;
    set_dropped = 1'b0;
  endfunction

  // writes both registers, one per cycle; starts and ends on a falling edge
  task automatic set_config(input logic [CfgW-1:0] len, input logic [CfgW-1:0] limit);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_SEQ_LENGTH;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    len_cfg = len;
    @(negedge clk_i);
    cfg_idx_i   <= REG_DISTANCE_LIMIT;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    limit_cfg = limit;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic randomise_config();
    logic [CfgW-1:0] len;
    logic [CfgW-1:0] limit;
    int unsigned     span;
    case ($urandom_range(0, 19))
      0:       len = 7'd1;
      1:       len = 7'd64;
      2:       len = 7'd0;
      3:       len = CfgW'($urandom_range(65, 127));
      default: len = CfgW'($urandom_range(1, 64));
    endcase
    span = (len > MaxLen) ? MaxLen : len;
    case ($urandom_range(0, 9))
      0:       limit = 7'd0;
      1:       limit = 7'd65;
      2:       limit = 7'd127;
      default: limit = CfgW'($urandom_range(0, span + 1));
    endcase
    set_config(len, limit);
  endtask

  // offers one word, sometimes with a random gap ahead of it; ends on a falling edge
  task automatic send_word(input logic [SeqBitsW-1:0] bits, input logic closing);
    if (idle_enable && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    sequence_bits_i <= bits;
    last_sequence_i <= closing;
    do @(posedge clk_i); while (in_stall_o);
    absorb_word(bits, closing);
    words_sent++;
    @(negedge clk_i);
  endtask

  // a set of related sequences: one base word with sparse flips, some words unrelated
  task automatic send_set(input int unsigned n);
    logic [SeqBitsW-1:0] base;
    logic [SeqBitsW-1:0] flips;
    int unsigned         sparsity;
    base     = {$urandom, $urandom};
    sparsity = $urandom_range(0, 6);
    for (int unsigned k = 0; k < n; k++) begin
      flips = {$urandom, $urandom};
      repeat (sparsity) flips &= {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) flips = {$urandom, $urandom};
      send_word(base ^ flips, k == n - 1);
    end
  endtask

  // mostly small sets, a few around full capacity and past it
  function automatic int unsigned pick_set_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 8);
    if (roll < 96) return $urandom_range(9, 20);
    return $urandom_range(60, 67);
  endfunction

  // drop valid, let every result through, then give the sequencer time to settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_weights.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // registers at their reset values: counting off, every weight 1.0
  task automatic test_reset_defaults();
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word(64'h0123_4567_89ab_cdef, 1'b1);
    // a set of a single word
    send_word({$urandom, $urandom}, 1'b1);
    wait_idle();
  endtask

  // limit past the length: every other word is a neighbour
  task automatic test_limit_above_length();
    set_config(7'd64, 7'd65);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    send_word(64'h5555_5555_5555_5555, 1'b1);
    wait_idle();
    set_config(7'd1, 7'd127);
    send_word(64'h0, 1'b0);
    send_word(64'h1, 1'b1);
    wait_idle();
  endtask

  // length zero: all distances zero, so limit one makes all words neighbours
  task automatic test_length_zero();
    set_config(7'd0, 7'd1);
    repeat (2) send_word({$urandom, $urandom}, 1'b0);
    send_word({$urandom, $urandom}, 1'b1);
    wait_idle();
  endtask

  // length past the maximum acts as full length, so bit 63 still counts
  task automatic test_length_clamp();
    set_config(7'd127, 7'd2);
    send_word(64'h0, 1'b0);
    send_word(64'h1, 1'b0);
    send_word(64'h8000_0000_0000_0000, 1'b0);
    send_word(64'h8000_0000_0000_0001, 1'b1);
    wait_idle();
  endtask

  // bits above the length are kept but never compared
  task automatic test_bits_above_length();
    set_config(7'd8, 7'd1);
    send_word(64'hdead_beef_cafe_0000, 1'b0);
    send_word(64'h1234_5678_9abc_de00, 1'b0);
    send_word(64'hffff_ffff_ffff_ff01, 1'b1);
    wait_idle();
  endtask

  // store full: two words past capacity, the closing one among them, then a clean set
  task automatic test_store_full();
    set_config(7'd64, 7'd40);
    send_set(SetCapacity + 2);
    send_set(2);
    wait_idle();
  endtask

  // receiver holds off for a long stretch while further sets queue up
  task automatic test_backpressure();
    randomise_config();
    hold_off_len = 400;
    send_set(12);
    send_set(10);
    send_set(3);
    wait_idle();
  endtask

  task automatic test_random_sets();
    int unsigned first;
    first = words_sent;
    while (words_sent - first < 130) begin
      gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
      randomise_config();
      repeat ($urandom_range(1, 3)) send_set(pick_set_size());
      wait_idle();
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_no_idling();
    idle_enable = 1'b0;
    repeat (4) begin
      randomise_config();
      repeat (2) send_set($urandom_range(1, 6));
      wait_idle();
    end
  endtask

  // receiver stall: long hold-off on request, otherwise random bursts
  initial begin : result_stall
    int unsigned span;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_len != 0) begin
        span         = hold_off_len;
        hold_off_len = 0;
        out_stall_i <= 1'b1;
        for (int unsigned c = 0; c < span; c++) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        span = $urandom_range(1, 15);
        out_stall_i <= 1'b1;
        repeat (span) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // compare every accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_weights.size() == 0) begin
        $error("unexpected result word: index %0d count %0d", sequence_index_o,
               neighbour_count_o);
        mismatches++;
      end else begin
        want = expected_weights.pop_front();
        if (sequence_index_o !== want.seq_idx) begin
          $error("sequence_index: expected %0d, got %0d", want.seq_idx, sequence_index_o);
          mismatches++;
        end
        if (neighbour_count_o !== want.nbr_count) begin
          $error("neighbour_count: expected %0d, got %0d", want.nbr_count, neighbour_count_o);
          mismatches++;
        end
        if (weight_q16_o !== want.weight) begin
          $error("weight_q16: expected %0d, got %0d", want.weight, weight_q16_o);
          mismatches++;
        end
        if (overflow_flag_o !== want.overflow) begin
          $error("overflow_flag: expected %0d, got %0d", want.overflow, overflow_flag_o);
          mismatches++;
        end
        if (last_result_o !== want.closing) begin
          $error("last_result: expected %0d, got %0d", want.closing, last_result_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_SEQ_LENGTH;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    sequence_bits_i = '0;
    last_sequence_i = 1'b0;
    len_cfg         = SEQ_LENGTH_RST;
    limit_cfg       = DISTANCE_LIMIT_RST;
    held_words      = 0;
    set_dropped     = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_limit_above_length();
    test_length_zero();
    test_length_clamp();
    test_bits_above_length();
    test_store_full();
    test_backpressure();
    test_random_sets();
    test_no_idling();

    if (mismatches == 0 && expected_weights.size() == 0) begin
      $display("sequence_similarity_reweighting_tb: clean");
    end else begin
      $display("sequence_similarity_reweighting_tb: errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("sequence_similarity_reweighting_tb: errors");
    $finish;
  end

endmodule
